FILE: sv/latest_value_buffer_exchange_defines.svh
// assertion macros for the latest value buffer exchange
`ifndef LATEST_VALUE_BUFFER_EXCHANGE_DEFINES_SVH
`define LATEST_VALUE_BUFFER_EXCHANGE_DEFINES_SVH

`ifndef SYNTHESIS
// prop holds at every clock edge out of reset
`define LVBX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lvbx assertion failed");
// expr is never true out of reset
`define LVBX_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lvbx forbidden condition seen");
`else
`define LVBX_ASSERT(lbl, prop)
`define LVBX_NEVER(lbl, expr)
`endif

`endif

FILE: sv/lvbx_pkg.sv
// shared types and constants of the latest value buffer exchange
`default_nettype none
package lvbx_pkg;

  localparam int OP_W   = 2;
  localparam int RID_W  = 4;
  localparam int ST_W   = 3;
  localparam int IDX_W  = 5;
  localparam int OFS_W  = 21;
  localparam int SIZE_W = 16;
  localparam int RC_W   = 5;
  localparam int CIDX_W = 1;

  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_PUBLISH = 2'd1;
  localparam logic [OP_W-1:0] OP_GET     = 2'd2;
  localparam logic [OP_W-1:0] OP_POLL    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_PENDING = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_NEW     = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_ID     = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_READER_COUNT = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_BUFFER_SIZE  = 1'b1;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] index;
  } lvbx_res_t;

endpackage
`default_nettype wire

FILE: sv/lvbx_held_mem.sv
// holdings memory: buffer index held by each reader slot, one read and one write port
`default_nettype none
module lvbx_held_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    rd_data_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/lvbx_out_stage.sv
// result register: forms the byte offset and holds the item for the output channel
`default_nettype none
module lvbx_out_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire lvbx_pkg::lvbx_res_t       res,
  input  wire logic [lvbx_pkg::SIZE_W-1:0] buffer_size,
  output logic                           ready,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [31:0]                    out_tdata
);

  import lvbx_pkg::*;

  logic              vld_r;
  logic [ST_W-1:0]   status_r;
  logic [IDX_W-1:0]  index_r;
  logic [OFS_W-1:0]  offset_r;
  logic [OFS_W-1:0]  prod;

  assign ready = !vld_r || out_tready;
  // 5 by 16 bit product fits 21 bits exactly
  assign prod  = OFS_W'(res.index) * OFS_W'(buffer_size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      status_r <= res.status;
      index_r  <= res.index;
      offset_r <= prod;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, offset_r, index_r, status_r};

endmodule
`default_nettype wire

FILE: sv/latest_value_buffer_exchange.sv
// top level of the latest value buffer exchange: op sequencer, state registers, config
`default_nettype none
// Latest value buffer exchange: one writer and up to READER_SLOTS readers share
// nrd+2 buffers, where nrd is the effective reader count. Each input item is
// one operation (writer acquire, writer publish, reader get, reader poll) and
// gives exactly one result item with a status, the buffer index and its byte
// offset (index times buffer_size). Items are handled one at a time: in_tready
// is high while the sequencer is idle, and a finished result sits in an output
// register so the next item may be taken while it waits. Publish is accepted
// and its result handed over; get and poll do one read of the holdings memory,
// then compare and write back. Acquire accepts the item, streams every
// reader's holding out of the single read port of the holdings memory, then
// walks the buffer numbers downward for the highest free one and hands the
// result over. A result that cannot move into a full output register waits
// while the receiver stalls. reader_count 0 acts as 1, a count above
// READER_SLOTS acts as READER_SLOTS. Configuration is to be written by the
// user only while the block is idle; the block itself does not enforce
// this. No clearing pass is needed after reset.
module latest_value_buffer_exchange #(
  parameter int READER_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [lvbx_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [lvbx_pkg::SIZE_W-1:0] cfg_wdata,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // op[1:0], reader_id[5:2], zero pad
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // status[2:0], buffer_index[7:3],
                                       // buffer_offset[28:8], zero pad
);

  import lvbx_pkg::*;

  `include "latest_value_buffer_exchange_defines.svh"

  // the 5 bit reader_count caps the effective reader count at 31
  localparam int NRD_MAX  = (READER_SLOTS < 31) ? READER_SLOTS : 31;
  localparam int NBUF_MAX = NRD_MAX + 2;
  localparam int BIW      = $clog2(NBUF_MAX);       // buffer index width
  localparam int NBW      = $clog2(NBUF_MAX + 1);   // buffer count width
  localparam int NRW      = $clog2(NRD_MAX + 1);    // reader count width
  localparam int AW       = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int IXW      = (BIW > IDX_W) ? BIW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_HELD,
    S_EMIT
  } state_t;

  // config registers
  logic [RC_W-1:0]   reader_count_r;
  logic [SIZE_W-1:0] buffer_size_r;

  // exchange state
  state_t            state_r, state_nxt;
  logic [BIW-1:0]    latest_r, latest_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [BIW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [RID_W-1:0]  rid_r, rid_nxt;
  logic [NRW-1:0]    cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [NBUF_MAX-1:0] used_r, used_nxt;
  logic [BIW-1:0]    pick_r, pick_nxt;
  lvbx_res_t         res_r, res_nxt;

  // derived
  logic [NRW-1:0]    nrd;
  logic [NBW-1:0]    nbuf;
  logic [OP_W-1:0]   in_op;
  logic [RID_W-1:0]  in_rid;
  logic              in_acc;

  // holdings memory ports
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [BIW-1:0]    mem_rd_data;
  logic              mem_wr_en;

  // output stage
  logic              os_ready;
  logic              os_push;

  function automatic logic [IDX_W-1:0] to_idx(input logic [BIW-1:0] v);
    logic [IXW-1:0] w;
    w = IXW'(v);
    return w[IDX_W-1:0];
  endfunction

  // effective reader count: zero acts as one, above the limit acts as the limit
  always_comb begin
    if (reader_count_r == '0) begin
      nrd = NRW'(1);
    end else if (32'(reader_count_r) > READER_SLOTS) begin
      nrd = NRW'(READER_SLOTS);
    end else begin
      nrd = NRW'(reader_count_r);
    end
  end
  assign nbuf = NBW'(nrd) + NBW'(2);

  assign in_op     = in_tdata[1:0];
  assign in_rid    = in_tdata[5:2];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reader_count_r <= RC_W'(1);
      buffer_size_r  <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READER_COUNT: reader_count_r <= cfg_wdata[RC_W-1:0];
        CFG_BUFFER_SIZE:  buffer_size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    latest_nxt   = latest_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    op_nxt       = op_r;
    rid_nxt      = rid_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = rd_vld_r;
    used_nxt     = used_r;
    pick_nxt     = pick_r;
    res_nxt      = res_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = AW'(cnt_r);
    mem_wr_en    = 1'b0;
    os_push      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_op;
          rid_nxt = in_rid;
          case (in_op)
            OP_ACQUIRE: begin
              // latest buffer is taken unless it lies beyond the buffer count
              used_nxt = '0;
              if (32'(latest_r) < 32'(nbuf)) begin
                used_nxt[latest_r] = 1'b1;
              end
              cnt_nxt    = '0;
              rd_vld_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            OP_PUBLISH: begin
              if (pend_vld_r) begin
                latest_nxt   = pend_idx_r;
                pend_vld_nxt = 1'b0;
                res_nxt      = '{status: ST_OK, index: to_idx(pend_idx_r)};
              end else begin
                res_nxt = '{status: ST_NO_PENDING, index: '0};
              end
              state_nxt = S_EMIT;
            end
            default: begin
              if (32'(in_rid) >= 32'(nrd)) begin
                res_nxt   = '{status: ST_BAD_ID, index: '0};
                state_nxt = S_EMIT;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_rid);
                state_nxt   = S_HELD;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one reader read per cycle, mark the previous one's buffer
        if (rd_vld_r && (32'(mem_rd_data) < 32'(nbuf))) begin
          used_nxt[mem_rd_data] = 1'b1;
        end
        mem_rd_en  = (32'(cnt_r) < 32'(nrd));
        rd_vld_nxt = mem_rd_en;
        if (mem_rd_en) begin
          cnt_nxt = cnt_r + NRW'(1);
        end else if (!rd_vld_r) begin
          pick_nxt  = BIW'(nbuf - NBW'(1));
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        // walk downward for the highest free buffer
        if (!used_r[pick_r]) begin
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = pick_r;
          res_nxt      = '{status: ST_OK, index: to_idx(pick_r)};
          state_nxt    = S_EMIT;
        end else if (pick_r == '0) begin
          pend_vld_nxt = 1'b0;
          res_nxt      = '{status: ST_NO_FREE, index: '0};
          state_nxt    = S_EMIT;
        end else begin
          pick_nxt = pick_r - BIW'(1);
        end
      end

      S_HELD: begin
        // holding of rid_r is on the read port now
        if (32'(latest_r) >= 32'(nbuf)) begin
          res_nxt = '{status: ST_NO_NEW, index: '0};
        end else if ((op_r == OP_POLL) && (mem_rd_data == latest_r)) begin
          res_nxt = '{status: ST_NO_NEW, index: '0};
        end else begin
          mem_wr_en = 1'b1;
          res_nxt   = '{status: ST_OK, index: to_idx(latest_r)};
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        os_push = 1'b1;
        if (os_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      latest_r   <= '0;
      pend_vld_r <= 1'b0;
      pend_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      latest_r   <= latest_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_idx_r <= pend_idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
    op_r   <= op_nxt;
    rid_r  <= rid_nxt;
    used_r <= used_nxt;
    pick_r <= pick_nxt;
    res_r  <= res_nxt;
  end

  lvbx_held_mem #(
    .DEPTH (READER_SLOTS),
    .AW    (AW),
    .DW    (BIW)
  ) u_held_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (AW'(rid_r)),
    .wr_data (latest_r)
  );

  lvbx_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (os_push),
    .res         (res_r),
    .buffer_size (buffer_size_r),
    .ready       (os_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // one item in flight: no second item taken right after one is accepted
  `LVBX_ASSERT(a_one_in_flight, in_acc |=> !in_tready)
  // failing status always comes with zero index and offset
  `LVBX_ASSERT(a_fail_zero, (out_tvalid && (out_tdata[2:0] != ST_OK)) |-> (out_tdata[28:3] == '0))
  // status code stays within the defined set
  `LVBX_NEVER(a_status_range, out_tvalid && (out_tdata[2:0] > ST_BAD_ID))
  // a successful acquire leaves a pending buffer behind
  `LVBX_ASSERT(a_acq_pending, (os_push && os_ready && (op_r == OP_ACQUIRE) && (res_r.status == ST_OK)) |=> pend_vld_r)

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the latest value buffer exchange: directed table, then random ops checked by a predictor
module tb_top;
  import lvbx_pkg::*;

  localparam int MAX_RD          = 16;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int HOLD_CYCLES     = 300;     // long receiver hold-off, fills the block
  localparam int TAIL_CYCLES     = 50;
  localparam int RAND_PER_PHASE  = 191;
  localparam int PHASES          = 8;

  // expected result item
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] index;
    logic [OFS_W-1:0] offset;
  } outcome_t;

  // one row of the directed table: a register write or an op item
  typedef struct packed {
    bit                  is_cfg;
    logic [CIDX_W-1:0]   reg_idx;
    logic [SIZE_W-1:0]   wdata;
    logic [OP_W-1:0]     op;
    logic [RID_W-1:0]    rid;
    bit                  typed;   // expected outcome written out in the row
    outcome_t            want;
  } step_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [SIZE_W-1:0]   cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;    // op[1:0], reader_id[5:2], zero pad
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;   // status[2:0], buffer_index[7:3], buffer_offset[28:8], zero pad

  // run control of the sender and receiver sides and the watchdog
  logic                idle_on;
  logic                hold_req;
  bit                  hold_done = 1'b0;
  int                  hold_left = 0;
  int                  stall_left = 0;
  int                  cycle_count = 0;

  // predictor state: configuration and exchange bookkeeping
  logic [RC_W-1:0]     rc_cfg;
  logic [SIZE_W-1:0]   bsize_cfg;
  logic [IDX_W-1:0]    newest_buf;
  logic [IDX_W-1:0]    claimed_by[MAX_RD];
  bit                  staged_valid;
  logic [IDX_W-1:0]    staged_buf;

  // expected results, oldest first
  outcome_t            outcome_q[$];
  step_t               directed_q[$];

  int                  mismatches = 0;
  int                  outcomes_seen = 0;
  int                  items_sent;
  int                  settings_used;
  int                  status_hits[8] = '{default: 0};

  latest_value_buffer_exchange #(
    .READER_SLOTS (MAX_RD)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reader count as the block uses it: 0 acts as 1, above the maximum clips
  function automatic int eff_readers();
    if (rc_cfg == 0) return 1;
    if (rc_cfg > MAX_RD) return MAX_RD;
    return int'(rc_cfg);
  endfunction

  // applies one op to the predictor state and returns the result it causes
  function automatic outcome_t apply_op(logic [OP_W-1:0] op, logic [RID_W-1:0] rid);
    outcome_t r;
    bit       taken[MAX_RD+2];
    int       nrd;
    int       nbuf;
    nrd      = eff_readers();
    nbuf     = nrd + 2;
    r.status = ST_OK;
    r.index  = '0;
    case (op)
      OP_ACQUIRE: begin
        foreach (taken[i]) taken[i] = 1'b0;
        // stale indexes beyond the buffer count do not block anything
        if (newest_buf < nbuf) taken[newest_buf] = 1'b1;
        for (int i = 0; i < nrd; i++) begin
          if (claimed_by[i] < nbuf) taken[claimed_by[i]] = 1'b1;
        end
        // highest free buffer wins; a new acquire replaces the staged one
        r.status = ST_NO_FREE;
        for (int i = 0; i < nbuf; i++) begin
          if (!taken[i]) begin
            r.status = ST_OK;
            r.index  = IDX_W'(i);
          end
        end
        staged_valid = (r.status == ST_OK);
        if (staged_valid) staged_buf = r.index;
      end
      OP_PUBLISH: begin
        if (!staged_valid) begin
          r.status = ST_NO_PENDING;
        end else begin
          newest_buf   = staged_buf;
          staged_valid = 1'b0;
          r.index      = staged_buf;
        end
      end
      default: begin
        // reader get and poll
        if (rid >= nrd) begin
          r.status = ST_BAD_ID;
        end else if (newest_buf >= nbuf) begin
          r.status = ST_NO_NEW;
        end else if (op == OP_POLL && claimed_by[rid] == newest_buf) begin
          r.status = ST_NO_NEW;
        end else begin
          claimed_by[rid] = newest_buf;
          r.index         = newest_buf;
        end
      end
    endcase
    r.offset = r.index * bsize_cfg;  // evaluated at 21 bits, wraps like the block
    return r;
  endfunction

  function automatic step_t mk_cfg(logic [CIDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.wdata   = data;
    return s;
  endfunction

  function automatic step_t mk_item(logic [OP_W-1:0] op, logic [RID_W-1:0] rid);
    step_t s;
    s     = '0;
    s.op  = op;
    s.rid = rid;
    return s;
  endfunction

  function automatic step_t mk_check(logic [OP_W-1:0] op, logic [RID_W-1:0] rid,
                                     logic [ST_W-1:0] st, logic [IDX_W-1:0] idx,
                                     logic [OFS_W-1:0] ofs);
    step_t s;
    s             = mk_item(op, rid);
    s.typed       = 1'b1;
    s.want.status = st;
    s.want.index  = idx;
    s.want.offset = ofs;
    return s;
  endfunction

  // register write, only issued while nothing is outstanding
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_READER_COUNT) begin
      rc_cfg = data[RC_W-1:0];
      settings_used++;
    end else begin
      bsize_cfg = data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offers one item, records its expected result once accepted
  task automatic send_item(logic [OP_W-1:0] op, logic [RID_W-1:0] rid, bit typed,
                           outcome_t typed_out);
    outcome_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, rid, op};
    do @(posedge clk); while (!in_tready);
    predicted = apply_op(op, rid);
    outcome_q.push_back(typed ? typed_out : predicted);
    items_sent++;
    // occasional sender gap burst while idling is on
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_outcome(logic [31:0] d);
    outcome_t got;
    outcome_t want;
    got.status = d[2:0];
    got.index  = d[7:3];
    got.offset = d[28:8];
    outcomes_seen++;
    if (outcome_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result item %h with nothing outstanding", d);
      return;
    end
    want = outcome_q.pop_front();
    status_hits[want.status]++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result %0d mismatch: status exp %0d got %0d, ",
                  "index exp %0d got %0d, offset exp %0d got %0d"},
                 outcomes_seen, want.status, got.status, want.index, got.index,
                 want.offset, got.offset);
    end
  endtask

  // result side: check accepted items, then pick next ready
  always @(posedge clk) begin : rx_side
    logic ready_next;
    if (rst_n && out_tvalid && out_tready) check_outcome(out_tdata);
    // one long hold-off, started the first time the sender asks for it
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      // occasional stall burst while idling is on
      stall_left = $urandom_range(0, 4);
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    out_tready <= ready_next;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, outcome_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    int rc_plan[PHASES];
    int bs_plan[PHASES];
    int nrd;
    int pick;
    int rc_val;
    logic [OP_W-1:0]   op;
    logic [RID_W-1:0]  rid;
    logic [SIZE_W-1:0] rc_word;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_READER_COUNT;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    idle_on   <= 1'b1;
    hold_req  <= 1'b0;
    items_sent    = 0;
    settings_used = 1;

    // predictor reset state
    rc_cfg       = 1;
    bsize_cfg    = 1;
    newest_buf   = '0;
    staged_valid = 1'b0;
    staged_buf   = '0;
    foreach (claimed_by[i]) claimed_by[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, one reader, three buffers, size 1
    directed_q.push_back(mk_check(OP_POLL, 4'd0, ST_NO_NEW, 5'd0, 21'd0));   // poll before any publish
    directed_q.push_back(mk_check(OP_PUBLISH, 4'd0, ST_NO_PENDING, 5'd0, 21'd0));
    directed_q.push_back(mk_check(OP_GET, 4'd1, ST_BAD_ID, 5'd0, 21'd0));
    directed_q.push_back(mk_check(OP_POLL, 4'd15, ST_BAD_ID, 5'd0, 21'd0));
    directed_q.push_back(mk_check(OP_ACQUIRE, 4'd9, ST_OK, 5'd2, 21'd2));
    directed_q.push_back(mk_check(OP_ACQUIRE, 4'd0, ST_OK, 5'd2, 21'd2));    // replaces staged
    directed_q.push_back(mk_check(OP_PUBLISH, 4'd0, ST_OK, 5'd2, 21'd2));
    directed_q.push_back(mk_item(OP_POLL, 4'd0));
    directed_q.push_back(mk_item(OP_POLL, 4'd0));                           // nothing new
    directed_q.push_back(mk_item(OP_GET, 4'd0));
    directed_q.push_back(mk_item(OP_ACQUIRE, 4'd0));
    directed_q.push_back(mk_item(OP_PUBLISH, 4'd0));
    directed_q.push_back(mk_item(OP_ACQUIRE, 4'd0));
    // widest setting: 16 readers, 18 buffers, largest size
    directed_q.push_back(mk_cfg(CFG_READER_COUNT, 16'd16));
    directed_q.push_back(mk_cfg(CFG_BUFFER_SIZE, 16'hffff));
    directed_q.push_back(mk_check(OP_ACQUIRE, 4'd0, ST_OK, 5'd17, 21'd1114095));
    directed_q.push_back(mk_item(OP_PUBLISH, 4'd0));
    directed_q.push_back(mk_item(OP_GET, 4'd15));
    directed_q.push_back(mk_item(OP_POLL, 4'd15));
    directed_q.push_back(mk_item(OP_POLL, 4'd7));
    // shrink with latest beyond the buffer count, zero acts as one reader
    directed_q.push_back(mk_cfg(CFG_READER_COUNT, 16'd0));
    directed_q.push_back(mk_item(OP_GET, 4'd0));
    directed_q.push_back(mk_item(OP_ACQUIRE, 4'd0));
    directed_q.push_back(mk_item(OP_GET, 4'd1));
    // count above the maximum clips, zero size gives zero offsets
    directed_q.push_back(mk_cfg(CFG_READER_COUNT, 16'd31));
    directed_q.push_back(mk_cfg(CFG_BUFFER_SIZE, 16'd0));
    directed_q.push_back(mk_item(OP_GET, 4'd15));
    directed_q.push_back(mk_item(OP_ACQUIRE, 4'd0));
    directed_q.push_back(mk_item(OP_PUBLISH, 4'd0));
    directed_q.push_back(mk_item(OP_PUBLISH, 4'd0));

    foreach (directed_q[k]) begin
      if (directed_q[k].is_cfg) begin
        drain();
        write_reg(directed_q[k].reg_idx, directed_q[k].wdata);
      end else begin
        send_item(directed_q[k].op, directed_q[k].rid, directed_q[k].typed,
                  directed_q[k].want);
      end
    end

    // random phases, -1 in a plan means a random value
    rc_plan = '{16, 1, 0, 31, -1, -1, 16, 5};
    bs_plan = '{65535, 65535, -1, -1, 0, -1, 1, -1};

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // last phase runs without any idling
      if (p == PHASES - 1) idle_on <= 1'b0;
      rc_val  = (rc_plan[p] < 0) ? int'($urandom_range(1, MAX_RD)) : rc_plan[p];
      rc_word = 16'(rc_val);
      // upper bits of the count write are don't-care, toggle them in one phase
      if (p == 5) rc_word[SIZE_W-1:RC_W] = 11'($urandom);
      write_reg(CFG_READER_COUNT, rc_word);
      write_reg(CFG_BUFFER_SIZE,
                (bs_plan[p] < 0) ? 16'($urandom_range(1, 65535)) : 16'(bs_plan[p]));
      nrd = eff_readers();

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 0 && n == 40) hold_req <= 1'b1;
        // sender waits for every outstanding result once mid-phase
        if (p == 3 && n == 95) drain();
        // mostly writer acquire/publish cycles and in-range readers
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_ACQUIRE;
        else if (pick < 55) op = OP_PUBLISH;
        else if (pick < 75) op = OP_GET;
        else                op = OP_POLL;
        if ($urandom_range(0, 99) < 85) rid = RID_W'($urandom_range(0, nrd - 1));
        else                            rid = RID_W'($urandom_range(0, 15));
        send_item(op, rid, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d items over %0d reader count settings, %0d results checked",
             items_sent, settings_used, outcomes_seen);
    $display("status mix: ok %0d, nothing pending %0d, no new data %0d, bad reader %0d",
             status_hits[ST_OK], status_hits[ST_NO_PENDING], status_hits[ST_NO_NEW],
             status_hits[ST_BAD_ID]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
